@@ rtl/core/stsu_pkg.sv @@
// shared constants, types and saturation helpers of the stereo to surround upmix unit
package stsu_pkg;

    // sample and filter geometry
    localparam int SAMPLE_WIDTH  = 24;
    localparam int FILTER_STAGES = 3;

    // widths of the datapath
    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = 33;                 // coefficient, one extra bit for negation
    localparam int PW     = SW + CW;            // one product
    localparam int AW     = PW + 3;             // sum of five products
    localparam int STG_AW = (FILTER_STAGES > 1) ? $clog2(FILTER_STAGES) : 1;
    localparam int IN_W   = ((2 * SW + 7) / 8) * 8;
    localparam int OUT_W  = ((6 * SW + 7) / 8) * 8;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_B0   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_B1   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_B2   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_A1   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_A2   = 3'd5;

    // reset values of the coefficients, Q2.30
    localparam logic signed [CFG_DW-1:0] B0_RST = 32'sd2713906;
    localparam logic signed [CFG_DW-1:0] B1_RST = 32'sd5427813;
    localparam logic signed [CFG_DW-1:0] B2_RST = 32'sd2713906;
    localparam logic signed [CFG_DW-1:0] A1_RST = -32'sd1988727146;
    localparam logic signed [CFG_DW-1:0] A2_RST = 32'sd925939787;

    // gains in Q3.30
    localparam logic signed [CW-1:0] GAIN_M4DB = 33'sd677484920;
    localparam logic signed [CW-1:0] GAIN_M2DB = 33'sd852903196;

    // sample limits
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [AW-1:0] ACC_SMAX  = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] ACC_SMIN  = AW'(-(64'sd1 <<< (SW - 1)));
    localparam logic signed [AW-1:0] ACC_HALF  = AW'(64'sd1 <<< 29);

    // one history row: two past inputs and two past outputs of a stage
    typedef struct packed {
        logic signed [SW-1:0] x1;
        logic signed [SW-1:0] x2;
        logic signed [SW-1:0] y1;
        logic signed [SW-1:0] y2;
    } t_row;

    // round half up from Q30 and clamp to the sample range
    function automatic logic signed [SW-1:0] sat_rnd(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] t;
        t = (v + ACC_HALF) >>> 30;
        if (t > ACC_SMAX) begin
            return SMAX;
        end else if (t < ACC_SMIN) begin
            return SMIN;
        end
        return t[SW-1:0];
    endfunction

    // negate with the most negative sample clamped
    function automatic logic signed [SW-1:0] sat_neg(input logic signed [SW-1:0] v);
        if (v == SMIN) begin
            return SMAX;
        end
        return -v;
    endfunction

    // double with clamping
    function automatic logic signed [SW-1:0] sat_dbl(input logic signed [SW-1:0] v);
        if (v[SW-1] != v[SW-2]) begin
            return v[SW-1] ? SMIN : SMAX;
        end
        return {v[SW-2:0], 1'b0};
    endfunction

endpackage

@@ rtl/core/stereo_to_surround_upmix_unit.sv @@
// stereo to six channel upmix with a cascaded biquad low-pass for the lfe channel
//
// input stream: one stereo frame per item on s_axis_*, left in the low bits.
// output stream: one six channel frame per item on m_axis_*, held in an
// output register until taken.
// configuration: i_cfg_we writes register i_cfg_addr (0 mode, 1..5 b0 b1 b2
// a1 a2) with i_cfg_wdata at the clock edge; the user must write only while
// no item is in work, the block itself does not enforce it. a frame runs
// through one shared 33 x 24 multiplier with a registered product: the left
// and right gains in mode 0, also the center gain and, per filter stage, a
// history read and five products and sums in mode 1; then the result moves
// into the output register and an idle step follows before the next frame
// is taken. the filter history lives in a one-row-per-stage memory with a
// registered read, read in the cycle before the stage's first product and
// written back when the stage output is ready.
// s_axis_tready is high whenever no frame is in work, also while a result
// waits; a frame that finishes while the previous result is still not taken
// waits in the last step until m_axis_tready frees the output register.
// synchronous reset clears the mode, loads the default coefficients and marks
// all history rows as zero at once; there is no clearing pass.
module stereo_to_surround_upmix_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [stsu_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [stsu_pkg::CFG_DW-1:0]   i_cfg_wdata,
    // stereo input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [stsu_pkg::IN_W-1:0]     s_axis_tdata,  // left_in, right_in
    // six channel output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // left_out, center_out, right_out, left_surround_out, right_surround_out, lfe_out
    output logic [stsu_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int SW = stsu_pkg::SW;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ML   = 4'd1;
    localparam logic [3:0] ST_WL   = 4'd2;
    localparam logic [3:0] ST_MR   = 4'd3;
    localparam logic [3:0] ST_WR   = 4'd4;
    localparam logic [3:0] ST_MC   = 4'd5;
    localparam logic [3:0] ST_WC   = 4'd6;
    localparam logic [3:0] ST_RD   = 4'd7;
    localparam logic [3:0] ST_FM   = 4'd8;
    localparam logic [3:0] ST_FA   = 4'd9;
    localparam logic [3:0] ST_FY   = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    // biquad terms in the order they are accumulated
    localparam logic [2:0] TERM_X0 = 3'd0;
    localparam logic [2:0] TERM_X1 = 3'd1;
    localparam logic [2:0] TERM_X2 = 3'd2;
    localparam logic [2:0] TERM_Y1 = 3'd3;
    localparam logic [2:0] TERM_Y2 = 3'd4;

    localparam logic [stsu_pkg::STG_AW-1:0] STG_LAST =
        stsu_pkg::STG_AW'(stsu_pkg::FILTER_STAGES - 1);

    // configuration registers
    logic                                   r_mode;
    logic signed [stsu_pkg::CFG_DW-1:0]     r_b0, r_b1, r_b2, r_a1, r_a2;

    // sequencer and datapath registers
    logic [3:0]                             r_state;
    logic [2:0]                             r_term;
    logic [stsu_pkg::STG_AW-1:0]            r_stg;
    logic signed [SW-1:0]                   r_lin, r_rin;
    logic signed [SW-1:0]                   r_l, r_r, r_c, r_x;
    logic signed [stsu_pkg::PW-1:0]         r_prod;
    logic signed [stsu_pkg::AW-1:0]         r_acc;

    // history memory and its valid bits
    stsu_pkg::t_row                         mem_hist [stsu_pkg::FILTER_STAGES];
    stsu_pkg::t_row                         r_rdata;
    logic                                   r_rd_vld;
    logic [stsu_pkg::FILTER_STAGES-1:0]     r_vld;

    // output register
    logic                                   r_mvalid;
    logic [stsu_pkg::OUT_W-1:0]             r_mdata;

    logic                                   in_acc;
    logic                                   out_load;
    logic                                   mem_we;
    logic                                   mem_re;
    stsu_pkg::t_row                         row;
    stsu_pkg::t_row                         wrow;
    logic signed [stsu_pkg::CW-1:0]         mul_a;
    logic signed [SW-1:0]                   mul_b;
    logic signed [SW-1:0]                   y_new;
    logic signed [SW-1:0]                   half;
    logic signed [SW-1:0]                   c_new;
    logic [stsu_pkg::OUT_W-1:0]             out_word;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_mvalid || m_axis_tready);
    assign mem_re        = (r_state == ST_RD);
    assign mem_we        = (r_state == ST_FY);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    // history row of the current stage, zero until first written
    assign row = r_rd_vld ? r_rdata : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_b0   <= stsu_pkg::B0_RST;
            r_b1   <= stsu_pkg::B1_RST;
            r_b2   <= stsu_pkg::B2_RST;
            r_a1   <= stsu_pkg::A1_RST;
            r_a2   <= stsu_pkg::A2_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                stsu_pkg::CFG_MODE: r_mode <= i_cfg_wdata[0];
                stsu_pkg::CFG_B0:   r_b0   <= i_cfg_wdata;
                stsu_pkg::CFG_B1:   r_b1   <= i_cfg_wdata;
                stsu_pkg::CFG_B2:   r_b2   <= i_cfg_wdata;
                stsu_pkg::CFG_A1:   r_a1   <= i_cfg_wdata;
                stsu_pkg::CFG_A2:   r_a2   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // multiplier operand selection
    always_comb begin
        mul_a = stsu_pkg::GAIN_M4DB;
        mul_b = r_lin;
        case (r_state)
            ST_MR: begin
                mul_b = r_rin;
            end
            ST_MC: begin
                mul_a = stsu_pkg::GAIN_M2DB;
                mul_b = r_r;
            end
            ST_FM: begin
                case (r_term)
                    TERM_X0: begin
                        mul_a = stsu_pkg::CW'(r_b0);
                        mul_b = r_x;
                    end
                    TERM_X1: begin
                        mul_a = stsu_pkg::CW'(r_b1);
                        mul_b = row.x1;
                    end
                    TERM_X2: begin
                        mul_a = stsu_pkg::CW'(r_b2);
                        mul_b = row.x2;
                    end
                    TERM_Y1: begin
                        mul_a = -stsu_pkg::CW'(r_a1);
                        mul_b = row.y1;
                    end
                    default: begin
                        mul_a = -stsu_pkg::CW'(r_a2);
                        mul_b = row.y2;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // rounding of the product and of the stage sum
    assign half  = stsu_pkg::sat_rnd({{3{r_prod[stsu_pkg::PW-1]}}, r_prod});
    assign c_new = stsu_pkg::sat_dbl(half);
    assign y_new = stsu_pkg::sat_rnd(r_acc);

    // new history row after a stage
    always_comb begin
        wrow.x1 = r_x;
        wrow.x2 = row.x1;
        wrow.y1 = y_new;
        wrow.y2 = row.y1;
    end

    // history memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_hist[r_stg] <= wrow;
        end
        if (mem_re) begin
            r_rdata <= mem_hist[r_stg];
        end
    end

    // valid bits of the history rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (mem_we) begin
                r_vld[r_stg] <= 1'b1;
            end
            if (mem_re) begin
                r_rd_vld <= r_vld[r_stg];
            end
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_term  <= TERM_X0;
            r_stg   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_ML;
                    end
                end
                ST_ML: r_state <= ST_WL;
                ST_WL: r_state <= ST_MR;
                ST_MR: r_state <= ST_WR;
                ST_WR: r_state <= r_mode ? ST_MC : ST_OUT;
                ST_MC: r_state <= ST_WC;
                ST_WC: begin
                    r_stg   <= '0;
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_term  <= TERM_X0;
                    r_state <= ST_FM;
                end
                ST_FM: r_state <= ST_FA;
                ST_FA: begin
                    if (r_term == TERM_Y2) begin
                        r_state <= ST_FY;
                    end else begin
                        r_term  <= r_term + 3'd1;
                        r_state <= ST_FM;
                    end
                end
                ST_FY: begin
                    if (r_stg == STG_LAST) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_stg   <= r_stg + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // sample datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lin <= s_axis_tdata[SW-1:0];
            r_rin <= s_axis_tdata[2*SW-1:SW];
        end
        case (r_state)
            ST_WL: r_l <= half;
            ST_WR: begin
                r_r <= half;
                r_c <= '0;
                r_x <= '0;
            end
            ST_WC: begin
                r_c <= c_new;
                r_x <= stsu_pkg::sat_neg(c_new);
            end
            ST_RD: r_acc <= '0;
            ST_FA: r_acc <= r_acc + {{3{r_prod[stsu_pkg::PW-1]}}, r_prod};
            ST_FY: r_x <= y_new;
            default: ;
        endcase
    end

    // packing of the output frame
    always_comb begin
        out_word = '0;
        out_word[SW-1:0]      = r_l;
        out_word[2*SW-1:SW]   = r_c;
        out_word[3*SW-1:2*SW] = r_r;
        out_word[4*SW-1:3*SW] = stsu_pkg::sat_neg(r_l);
        out_word[5*SW-1:4*SW] = stsu_pkg::sat_neg(r_r);
        out_word[6*SW-1:5*SW] = r_x;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (out_load) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mdata <= out_word;
        end
    end

    // an accepted item starts the left gain product
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_ML))
        else $error("accepted item did not start the sequence");

    // in mode zero center and lfe leave as zero
    a_mode0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !r_mode) |=>
            (r_mdata[2*SW-1:SW] == '0 && r_mdata[6*SW-1:5*SW] == '0))
        else $error("center or lfe not zero in mode zero");

    // a written history row is marked valid
    a_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_vld[$past(r_stg)])
        else $error("history row not marked valid after write");

    // the stage counter stays within the cascade while filtering
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD || r_state == ST_FM || r_state == ST_FA || r_state == ST_FY)
            |-> (r_stg <= STG_LAST))
        else $error("stage counter out of range");

    // a waiting result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && !m_axis_tready && r_state == ST_OUT) |=> (r_state == ST_OUT))
        else $error("sequence left the output step while the result was stalled");

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench of the stereo to surround upmix unit with its own upmix and filter predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    SW            = stsu_pkg::SW;
    localparam int    CFG_AW        = stsu_pkg::CFG_AW;
    localparam int    CFG_DW        = stsu_pkg::CFG_DW;
    localparam int    IN_W          = stsu_pkg::IN_W;
    localparam int    OUT_W         = stsu_pkg::OUT_W;
    localparam int    FILTER_STAGES = stsu_pkg::FILTER_STAGES;

    localparam int    CYCLE_LIMIT   = 1_000_000;
    localparam int    PHASES        = 8;
    localparam int    PHASE_ITEMS   = 125;
    localparam int    LONG_HOLD     = 400;
    localparam int    SETTLE_CYCLES = 64;
    localparam longint HALF_Q30     = 64'sd1 <<< 29;

    // register indexes the block does not decode
    localparam logic [CFG_AW-1:0] CFG_SPARE0 = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE1 = 3'd7;

    // coefficient extremes
    localparam logic [CFG_DW-1:0] COEF_MAX = 32'h7fff_ffff;
    localparam logic [CFG_DW-1:0] COEF_MIN = 32'h8000_0000;

    // one six channel frame, left in the low bits as on m_axis_tdata
    typedef struct packed {
        logic signed [SW-1:0] lfe;
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] ls;
        logic signed [SW-1:0] right;
        logic signed [SW-1:0] center;
        logic signed [SW-1:0] left;
    } t_surround_frame;

    // one row of the directed part: a register write or an item
    typedef struct {
        bit                   is_cfg;
        logic [CFG_AW-1:0]    addr;
        logic [CFG_DW-1:0]    wdata;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        bit                   typed;
        t_surround_frame      want;
    } t_step;

    typedef enum int {COEF_DEFAULT, COEF_EXTREME, COEF_FULL, COEF_MILD} t_coef_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [CFG_DW-1:0]    i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;   // left_in, right_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // left_out, center_out, right_out, left_surround_out, right_surround_out, lfe_out
    logic [OUT_W-1:0]     m_axis_tdata;

    // predictor copy of the registers and the filter history
    bit     mode_q;
    longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    longint x1_h[FILTER_STAGES];
    longint x2_h[FILTER_STAGES];
    longint y1_h[FILTER_STAGES];
    longint y2_h[FILTER_STAGES];

    t_surround_frame pending_frames[$];
    t_step           directed_steps[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;
    int  hold_left      = 0;
    int  cycle_count    = 0;
    int  error_count    = 0;
    int  items_sent     = 0;
    int  frames_checked = 0;
    int  cfg_writes     = 0;

    string chan_name[6] = '{"left", "center", "right", "left_surround",
                            "right_surround", "lfe"};
    bit         phase_mode[PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1};
    t_coef_kind phase_kind[PHASES] = '{COEF_DEFAULT, COEF_FULL, COEF_EXTREME, COEF_MILD,
                                       COEF_FULL, COEF_DEFAULT, COEF_DEFAULT, COEF_EXTREME};

    stereo_to_surround_upmix_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // clamp to the sample range
    function automatic longint clamp_sample(longint v);
        if (v > longint'(stsu_pkg::SMAX)) begin
            return longint'(stsu_pkg::SMAX);
        end else if (v < longint'(stsu_pkg::SMIN)) begin
            return longint'(stsu_pkg::SMIN);
        end
        return v;
    endfunction

    // q30 gain, round half up, clamp
    function automatic longint gain_round(longint a, longint g);
        return clamp_sample((a * g + HALF_Q30) >>> 30);
    endfunction

    // one biquad stage of the lfe cascade, history updated
    function automatic longint biquad_stage(int k, longint x);
        longint acc;
        longint y;
        acc = coef_b0 * x + coef_b1 * x1_h[k] + coef_b2 * x2_h[k]
            - coef_a1 * y1_h[k] - coef_a2 * y2_h[k];
        y = clamp_sample((acc + HALF_Q30) >>> 30);
        x2_h[k] = x1_h[k];
        x1_h[k] = x;
        y2_h[k] = y1_h[k];
        y1_h[k] = y;
        return y;
    endfunction

    // expected six channel frame of one stereo item
    function automatic t_surround_frame upmix_frame(logic signed [SW-1:0] l_in,
                                                    logic signed [SW-1:0] r_in);
        t_surround_frame f;
        longint l, r, half, c, lfe, ls, rs;
        l   = gain_round(longint'(l_in), longint'(stsu_pkg::GAIN_M4DB));
        r   = gain_round(longint'(r_in), longint'(stsu_pkg::GAIN_M4DB));
        c   = 0;
        lfe = 0;
        if (mode_q) begin
            half = gain_round(r, longint'(stsu_pkg::GAIN_M2DB));
            c    = clamp_sample(half + half);
            lfe  = clamp_sample(-c);
            for (int k = 0; k < FILTER_STAGES; k++) begin
                lfe = biquad_stage(k, lfe);
            end
        end
        ls       = clamp_sample(-l);
        rs       = clamp_sample(-r);
        f.left   = l[SW-1:0];
        f.center = c[SW-1:0];
        f.right  = r[SW-1:0];
        f.ls     = ls[SW-1:0];
        f.rs     = rs[SW-1:0];
        f.lfe    = lfe[SW-1:0];
        return f;
    endfunction

    // mirror of a register write
    function automatic void apply_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] d);
        case (addr)
            stsu_pkg::CFG_MODE: mode_q  = d[0];
            stsu_pkg::CFG_B0:   coef_b0 = longint'($signed(d));
            stsu_pkg::CFG_B1:   coef_b1 = longint'($signed(d));
            stsu_pkg::CFG_B2:   coef_b2 = longint'($signed(d));
            stsu_pkg::CFG_A1:   coef_a1 = longint'($signed(d));
            stsu_pkg::CFG_A2:   coef_a2 = longint'($signed(d));
            default: ;
        endcase
    endfunction

    function automatic t_surround_frame make_frame(int l, int c, int r, int ls, int rs,
                                                   int lfe);
        t_surround_frame f;
        f.left   = SW'(l);
        f.center = SW'(c);
        f.right  = SW'(r);
        f.ls     = SW'(ls);
        f.rs     = SW'(rs);
        f.lfe    = SW'(lfe);
        return f;
    endfunction

    function automatic t_step step_cfg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] d);
        t_step s;
        s        = '{default: '0};
        s.is_cfg = 1'b1;
        s.addr   = addr;
        s.wdata  = d;
        return s;
    endfunction

    function automatic t_step step_item(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                                        bit typed, t_surround_frame want);
        t_step s;
        s       = '{default: '0};
        s.l     = l;
        s.r     = r;
        s.typed = typed;
        s.want  = want;
        return s;
    endfunction

    // random sample, weighted toward the extremes and small values
    function automatic logic signed [SW-1:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return stsu_pkg::SMAX;
        end else if (pick < 10) begin
            return stsu_pkg::SMIN;
        end else if (pick < 14) begin
            return '0;
        end else if (pick < 18) begin
            return '1;
        end else if (pick < 40) begin
            return SW'($urandom_range(2000) - 1000);
        end
        return SW'($urandom());
    endfunction

    function automatic logic [CFG_DW-1:0] coef_value(logic [CFG_AW-1:0] addr,
                                                     t_coef_kind kind);
        int pick;
        case (kind)
            COEF_DEFAULT: begin
                case (addr)
                    stsu_pkg::CFG_B0: return stsu_pkg::B0_RST;
                    stsu_pkg::CFG_B1: return stsu_pkg::B1_RST;
                    stsu_pkg::CFG_B2: return stsu_pkg::B2_RST;
                    stsu_pkg::CFG_A1: return stsu_pkg::A1_RST;
                    default:          return stsu_pkg::A2_RST;
                endcase
            end
            COEF_EXTREME: begin
                pick = $urandom_range(2);
                return (pick == 0) ? COEF_MAX : (pick == 1) ? COEF_MIN : '0;
            end
            COEF_MILD: return $urandom_range(32'h4000_0000) - 32'h2000_0000;
            default:   return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [SW-1:0] want, logic [SW-1:0] got);
        error_count++;
        $display("[%0d] mismatch %s: expected %0d got %0d", cycle_count, what,
                 $signed(want), $signed(got));
    endtask

    // register write on the config port, mirrored in the predictor
    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] d);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = d;
        apply_reg(addr, d);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // offer one stereo item, with random gaps before it
    task automatic send_frame(logic signed [SW-1:0] l, logic signed [SW-1:0] r,
                              bit typed, t_surround_frame want);
        t_surround_frame f;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {r, l};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        f = upmix_frame(l, r);
        pending_frames.push_back(typed ? want : f);
        items_sent++;
    endtask

    // stop offering and wait for every expected frame
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver: long hold on request, else random stalls
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_surround_frame want;
        logic [OUT_W-1:0] want_bits;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("frame with nothing expected, left", '0,
                                m_axis_tdata[SW-1:0]);
            end else begin
                want      = pending_frames.pop_front();
                want_bits = want;
                for (int k = 0; k < 6; k++) begin
                    if (m_axis_tdata[k*SW +: SW] !== want_bits[k*SW +: SW]) begin
                        report_mismatch(chan_name[k], want_bits[k*SW +: SW],
                                        m_axis_tdata[k*SW +: SW]);
                    end
                end
                frames_checked++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
                     pending_frames.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_step st;
        t_surround_frame none;
        logic [CFG_DW-1:0] mode_word;
        none          = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // predictor reset state
        mode_q  = 1'b0;
        coef_b0 = longint'(stsu_pkg::B0_RST);
        coef_b1 = longint'(stsu_pkg::B1_RST);
        coef_b2 = longint'(stsu_pkg::B2_RST);
        coef_a1 = longint'(stsu_pkg::A1_RST);
        coef_a2 = longint'(stsu_pkg::A2_RST);
        for (int k = 0; k < FILTER_STAGES; k++) begin
            x1_h[k] = 0;
            x2_h[k] = 0;
            y1_h[k] = 0;
            y2_h[k] = 0;
        end

        // directed rows: reset state, extremes, mode bits, spare indexes, filter overflow
        directed_steps.push_back(step_item('0, '0, 1, make_frame(0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(step_item(stsu_pkg::SMAX, stsu_pkg::SMIN, 1,
            make_frame(5292850, 0, -5292851, -5292850, 5292851, 0)));
        directed_steps.push_back(step_item(stsu_pkg::SMIN, stsu_pkg::SMAX, 1,
            make_frame(-5292851, 0, 5292850, 5292851, -5292850, 0)));
        directed_steps.push_back(step_item('1, SW'(1), 0, none));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_MODE, 32'hffff_ffff));
        directed_steps.push_back(step_item('0, '0, 0, none));
        directed_steps.push_back(step_item(stsu_pkg::SMAX, stsu_pkg::SMIN, 0, none));
        directed_steps.push_back(step_item(stsu_pkg::SMIN, stsu_pkg::SMAX, 0, none));
        directed_steps.push_back(step_item(SW'(1234), SW'(-5678), 0, none));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_MODE, 32'hffff_fffe));
        directed_steps.push_back(step_item(stsu_pkg::SMAX, stsu_pkg::SMIN, 1,
            make_frame(5292850, 0, -5292851, -5292850, 5292851, 0)));
        directed_steps.push_back(step_cfg(CFG_SPARE0, 32'hffff_ffff));
        directed_steps.push_back(step_cfg(CFG_SPARE1, 32'h0000_0001));
        directed_steps.push_back(step_item('0, stsu_pkg::SMIN, 0, none));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_MODE, 32'h0000_0001));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_B0, COEF_MAX));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_A1, COEF_MIN));
        directed_steps.push_back(step_item(stsu_pkg::SMIN, stsu_pkg::SMIN, 0, none));
        directed_steps.push_back(step_item(stsu_pkg::SMAX, stsu_pkg::SMAX, 0, none));
        directed_steps.push_back(step_item('0, '0, 0, none));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_B1, COEF_MIN));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_B2, COEF_MAX));
        directed_steps.push_back(step_cfg(stsu_pkg::CFG_A2, COEF_MAX));
        directed_steps.push_back(step_item(stsu_pkg::SMAX, stsu_pkg::SMIN, 0, none));
        directed_steps.push_back(step_item('0, stsu_pkg::SMAX, 0, none));
        directed_steps.push_back(step_item(SW'(-1), SW'(-1), 0, none));

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, register writes only once drained
        foreach (directed_steps[n]) begin
            st = directed_steps[n];
            if (st.is_cfg) begin
                drain();
                write_reg(st.addr, st.wdata);
            end else begin
                send_frame(st.l, st.r, st.typed, st.want);
            end
        end

        // random phases, each with its own settings and idling
        for (int p = 0; p < PHASES; p++) begin
            drain();
            send_idle_pct  = (p % 4 == 1) ? 81 : (p % 4 == 3) ? 27 : 0;
            recv_stall_pct = (p % 4 == 2) ? 81 : (p % 4 == 3) ? 27 : 0;
            mode_word = ($urandom() & ~32'h1) | CFG_DW'(phase_mode[p]);
            write_reg(stsu_pkg::CFG_MODE, mode_word);
            write_reg(stsu_pkg::CFG_B0, coef_value(stsu_pkg::CFG_B0, phase_kind[p]));
            write_reg(stsu_pkg::CFG_B1, coef_value(stsu_pkg::CFG_B1, phase_kind[p]));
            write_reg(stsu_pkg::CFG_B2, coef_value(stsu_pkg::CFG_B2, phase_kind[p]));
            write_reg(stsu_pkg::CFG_A1, coef_value(stsu_pkg::CFG_A1, phase_kind[p]));
            write_reg(stsu_pkg::CFG_A2, coef_value(stsu_pkg::CFG_A2, phase_kind[p]));
            write_reg($urandom_range(1) ? CFG_SPARE0 : CFG_SPARE1, $urandom());
            // receiver holds off while items keep coming, so the input backs up
            if (p == 2) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // sender pauses mid phase until everything is out
                if (p == 3 && i == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_frame(rand_sample(), rand_sample(), 0, none);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d items in a directed part and %0d random phases", items_sent,
                 PHASES);
        $display("%0d frames checked, %0d register writes, both modes, default/extreme/random taps",
                 frames_checked, cfg_writes);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
